// ===== hw/rtl/rclk_pkg.sv =====
package rclk_pkg;

    localparam int COORD_W         = 24;
    localparam int ID_W            = 16;
    localparam int SLOT_W          = 6;
    localparam int CFG_W           = 7;
    localparam int DIST_W          = 2 * COORD_W + 1;
    localparam int MAX_REGIONS_DEF = 64;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NEAREST = 2'd1,
        REQ_CENTER  = 2'd2
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic        [ID_W-1:0]    id;
    } entry_t;

    typedef struct packed {
        logic   match;
        entry_t entry;
    } scan_tag_t;

endpackage

// ===== hw/rtl/rclk_mem.sv =====
module rclk_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  rclk_pkg::entry_t  wdata,
    input  logic [AW-1:0]     raddr,
    output rclk_pkg::entry_t  rdata
);
    import rclk_pkg::*;

    entry_t mem_reg [DEPTH];
    entry_t rdata_reg;

    // Write port and registered read port, read-before-write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rclk_dist.sv =====
module rclk_dist (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic signed [rclk_pkg::COORD_W-1:0]     px,
    input  logic signed [rclk_pkg::COORD_W-1:0]     py,
    input  rclk_pkg::scan_tag_t                     tag_in,
    output logic                                    out_valid,
    output logic        [rclk_pkg::DIST_W-1:0]      dist_sum,
    output rclk_pkg::scan_tag_t                     tag_out,
    output logic                                    busy
);
    import rclk_pkg::*;

    localparam int SQ_W = 2 * COORD_W;

    logic                v1_reg, v2_reg, v3_reg;
    logic [COORD_W-1:0]  adx_reg, ady_reg;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg;
    logic [DIST_W-1:0]   sum_reg;
    scan_tag_t           tag1_reg, tag2_reg, tag3_reg;

    logic signed [COORD_W:0] dx, dy;
    logic        [COORD_W:0] ndx, ndy;
    logic [COORD_W-1:0]      adx_next, ady_next;

    // Difference of two in-range coordinates never exceeds COORD_W magnitude bits
    always_comb
    begin
        dx       = $signed({px[COORD_W-1], px}) -
                   $signed({tag_in.entry.x[COORD_W-1], tag_in.entry.x});
        dy       = $signed({py[COORD_W-1], py}) -
                   $signed({tag_in.entry.y[COORD_W-1], tag_in.entry.y});
        ndx      = -dx;
        ndy      = -dy;
        adx_next = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        ady_next = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Abs difference, then squares, then sum
    always_ff @(posedge clk)
    begin
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        tag1_reg <= tag_in;
        sqx_reg  <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg  <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
        tag2_reg <= tag1_reg;
        sum_reg  <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        tag3_reg <= tag2_reg;
    end

    assign out_valid = v3_reg;
    assign dist_sum  = sum_reg;
    assign tag_out   = tag3_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

// ===== hw/rtl/nearest_region_center_lookup_top.sv =====
// Channel  Direction  Handshake              Payload
// s        in         s_tvalid / s_tready    tuser: req_type; tdata: entry_index,
//                                            query_x, query_y, query_id
// m        out        m_tvalid / m_tready    tuser: found; tdata: region_id_out,
//                                            center_x_out, center_y_out
// cfg      in         cfg_valid / cfg_ready  cfg_data: region_count
//
// A load writes the entry into the table memory at accept. A nearest or
// center query scans n entries, n being the saturated region count: one
// table read per cycle from the table memory, then the read latency and the
// three-stage distance pipeline drain before the result lands. The input
// stays blocked for the whole scan.
// Reset clears the control state and region_count; table contents stay
// undefined until loaded. A stalled result holds in the output register; the
// next item is taken meanwhile and its result waits until the slot frees.
module nearest_region_center_lookup_top #(
    parameter int MAX_REGIONS = rclk_pkg::MAX_REGIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] entry_index, [29:6] query_x, [53:30] query_y, [69:54] query_id,
    // [71:70] zero
    input  logic [rclk_pkg::IN_DATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] region_id_out, [39:16] center_x_out, [63:40] center_y_out
    output logic [rclk_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [0] found
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rclk_pkg::CFG_W-1:0]          cfg_data
);
    import rclk_pkg::*;

    localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = ($clog2(MAX_REGIONS + 1) > CFG_W) ?
                           $clog2(MAX_REGIONS + 1) : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Unpacked input fields
    logic [SLOT_W-1:0]          in_slot;
    logic signed [COORD_W-1:0]  in_x, in_y;
    logic [ID_W-1:0]            in_id;
    req_t                       in_req;

    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_x    = s_tdata[SLOT_W +: COORD_W];
    assign in_y    = s_tdata[SLOT_W + COORD_W +: COORD_W];
    assign in_id   = s_tdata[SLOT_W + 2*COORD_W +: ID_W];
    assign in_req  = req_t'(s_tuser);

    state_t                     state_reg, state_next;
    req_t                       kind_reg, kind_next;
    logic [CFG_W-1:0]           count_reg, count_next;
    logic signed [COORD_W-1:0]  qx_reg, qx_next, qy_reg, qy_next;
    logic [ID_W-1:0]            qid_reg, qid_next;
    logic [CNT_W-1:0]           n_reg, n_next, cnt_reg, cnt_next;
    logic                       have_reg, have_next;
    logic [DIST_W-1:0]          best_reg, best_next;
    entry_t                     best_entry_reg, best_entry_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_found_reg, out_found_next;
    entry_t                     out_entry_reg, out_entry_next;
    logic                       rv_reg, rv_next;

    logic                       accept;
    logic                       mem_we;
    logic                       rd_en;
    logic [CNT_W-1:0]           cfg_ext, n_sat;
    entry_t                     wr_entry, rd_entry;
    scan_tag_t                  tag_in, tag_out;
    logic                       d_valid, d_busy;
    logic [DIST_W-1:0]          d_dist;
    logic                       scan_end;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    // Clamp the region count to the table depth
    assign cfg_ext = CNT_W'(count_reg);
    assign n_sat   = (cfg_ext > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : cfg_ext;

    // Loads write straight into the table; a slot past the depth is dropped
    assign mem_we   = accept && (in_req == REQ_LOAD) &&
                      (32'(in_slot) < 32'(MAX_REGIONS));
    assign wr_entry = '{y: in_y, x: in_x, id: in_id};

    // Issue one table read per cycle while scanning
    assign rd_en = (state_reg == ST_SCAN) && (cnt_reg < n_reg);

    rclk_mem #(
        .DEPTH (MAX_REGIONS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_slot)),
        .wdata (wr_entry),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    assign tag_in = '{match: (rd_entry.id == qid_reg), entry: rd_entry};

    rclk_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rv_reg),
        .px        (qx_reg),
        .py        (qy_reg),
        .tag_in    (tag_in),
        .out_valid (d_valid),
        .dist_sum  (d_dist),
        .tag_out   (tag_out),
        .busy      (d_busy)
    );

    // Every read issued and the pipeline drained
    assign scan_end = (cnt_reg == n_reg) && !rv_reg && !d_busy;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        qid_next        = qid_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        have_next       = have_reg;
        best_next       = best_reg;
        best_entry_next = best_entry_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_entry_next  = out_entry_reg;
        rv_next         = rd_en;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Keep the first match for a center query, the strict minimum otherwise
        if (d_valid)
        begin
            if (kind_reg == REQ_NEAREST)
            begin
                if (!have_reg || (d_dist < best_reg))
                begin
                    have_next       = 1'b1;
                    best_next       = d_dist;
                    best_entry_next = tag_out.entry;
                end
            end
            else if (tag_out.match && !have_reg)
            begin
                have_next       = 1'b1;
                best_entry_next = tag_out.entry;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((in_req == REQ_NEAREST) || (in_req == REQ_CENTER)))
                begin
                    kind_next  = in_req;
                    qx_next    = in_x;
                    qy_next    = in_y;
                    qid_next   = in_id;
                    n_next     = n_sat;
                    cnt_next   = '0;
                    have_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register frees
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = have_reg;
                    out_entry_next = have_reg ? best_entry_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
            rv_reg        <= rv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        qid_reg        <= qid_next;
        best_reg       <= best_next;
        best_entry_reg <= best_entry_next;
        out_found_reg  <= out_found_next;
        out_entry_reg  <= out_entry_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_entry_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= n_reg))
        else $error("scan read counter ran past the region count");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("result without a match carries nonzero payload");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid || rv_reg) |-> (state_reg == ST_SCAN))
        else $error("scan pipeline active outside a scan");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without a finished scan");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !mem_we)
        else $error("table written during a scan");
`endif

endmodule
